// ===== rtl/three_channel_proportional_slow_pwm_defines.svh =====
// Assertion macros for the three-channel slow PWM checker.
// Clock clk and synchronous reset rst are taken from the scope of use.
`ifndef THREE_CHANNEL_PROPORTIONAL_SLOW_PWM_DEFINES_SVH
`define THREE_CHANNEL_PROPORTIONAL_SLOW_PWM_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define TCSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, quiet during reset
`define TCSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/tcsp_pkg.sv =====
// Shared types and constants of the three-channel slow PWM.
// No dependencies; used by every module of the block.
package tcsp_pkg;

  localparam int CYCLE_BITS = 10;
  localparam int PHASE_W    = CYCLE_BITS + 1;
  localparam int LEVEL_W    = 7;
  localparam int FLOW_W     = 11;
  localparam int NCH        = 3;
  localparam int CH_W       = $clog2(NCH);
  localparam int PROD_W     = LEVEL_W + CYCLE_BITS;
  localparam int CNT_W      = $clog2(CYCLE_BITS + 1);

  localparam logic [LEVEL_W-1:0]    LEVEL_CAP   = LEVEL_W'(100);
  localparam logic [CYCLE_BITS-1:0] CYCLE_RESET = CYCLE_BITS'(500);
  localparam logic [PHASE_W-1:0]    PHASE_MAX   = {PHASE_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_SET     = 2'd1,
    REQ_ENABLE  = 2'd2,
    REQ_DISABLE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    req_t               req_type;
    logic [LEVEL_W-1:0] level_a;
    logic [LEVEL_W-1:0] level_b;
    logic [LEVEL_W-1:0] level_c;
  } in_t;

  typedef struct packed {
    logic              drive_a;
    logic              drive_b;
    logic              drive_c;
    logic [FLOW_W-1:0] flow_a;
    logic [FLOW_W-1:0] flow_b;
    logic [FLOW_W-1:0] flow_c;
    logic              running;
  } out_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [LEVEL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [CYCLE_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/tcsp_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tcsp_pkg. The quotient is known to fit in CYCLE_BITS bits.
module tcsp_div (
  input  logic               clk,
  input  logic               rst,
  input  tcsp_pkg::div_req_t req,
  output tcsp_pkg::div_rsp_t rsp
);

  logic                                busy;
  logic                                done;
  logic [tcsp_pkg::CNT_W-1:0]          cnt;
  logic [tcsp_pkg::LEVEL_W-1:0]        rem;
  logic [tcsp_pkg::CYCLE_BITS-1:0]     low;
  logic [tcsp_pkg::CYCLE_BITS-1:0]     quo;
  logic [tcsp_pkg::LEVEL_W:0]          shifted;
  logic [tcsp_pkg::LEVEL_W+1:0]        diff;
  logic                                fit;

  // Trial subtraction of the divisor from the shifted remainder
  assign shifted = {rem, low[tcsp_pkg::CYCLE_BITS-1]};
  assign diff    = {1'b0, shifted} - {2'b00, req.divisor};
  assign fit     = ~diff[tcsp_pkg::LEVEL_W+1];

  // Control: bit counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= tcsp_pkg::CNT_W'(tcsp_pkg::CYCLE_BITS);
      end else if (busy) begin
        cnt <= cnt - tcsp_pkg::CNT_W'(1);
        if (cnt == tcsp_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the upper dividend bits are already below the divisor
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend[tcsp_pkg::PROD_W-1:tcsp_pkg::CYCLE_BITS];
      low <= req.dividend[tcsp_pkg::CYCLE_BITS-1:0];
    end else if (busy) begin
      rem <= fit ? diff[tcsp_pkg::LEVEL_W-1:0] : shifted[tcsp_pkg::LEVEL_W-1:0];
      low <= {low[tcsp_pkg::CYCLE_BITS-2:0], 1'b0};
      quo <= {quo[tcsp_pkg::CYCLE_BITS-2:0], fit};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/three_channel_proportional_slow_pwm.sv =====
// Three-channel slow PWM for pumps: top level with sequencer and channel state.
// Depends on tcsp_pkg and tcsp_div.
//
// Each input beat is a millisecond tick, a set of three levels, an enable or a
// disable, and gives exactly one result beat. A tick, enable or disable beat
// goes from the idle state to the done state, which loads the output register
// once it is free, and the input opens again when the sequencer is back in idle.
// A set beat works through the channels in turn on the one shared divider: per
// channel the product of the clipped level and cycle_ms is registered, the
// restoring divider is loaded, it resolves the on-time a bit per cycle against
// the largest level, and the on-time is stored. Its result is registered in the
// done state after the last channel. The input is not ready while a beat is in
// work; a finished result waits in the output register and only holds off the
// input once the next result is ready behind it.
// cycle_ms may be written at any time the block is idle; cfg_ready is always high.
module three_channel_proportional_slow_pwm (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tcsp_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tcsp_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcsp_pkg::CYCLE_BITS-1:0] cfg_data
);

  tcsp_pkg::state_t                  state, state_next;
  tcsp_pkg::div_req_t                div_req;
  tcsp_pkg::div_rsp_t                div_rsp;
  tcsp_pkg::out_t                    result;

  logic                              in_fire;
  logic                              out_free;
  logic [tcsp_pkg::CYCLE_BITS-1:0]   cycle_ms;
  logic                              active;
  logic [tcsp_pkg::PHASE_W-1:0]      phase;
  logic [tcsp_pkg::CYCLE_BITS-1:0]   on_time [tcsp_pkg::NCH];
  logic                              was_on  [tcsp_pkg::NCH];
  logic [tcsp_pkg::FLOW_W-1:0]       flow    [tcsp_pkg::NCH];
  logic [tcsp_pkg::LEVEL_W-1:0]      lv      [tcsp_pkg::NCH];
  logic [tcsp_pkg::LEVEL_W-1:0]      mx;
  logic [tcsp_pkg::CH_W-1:0]         ch;
  logic [tcsp_pkg::PROD_W-1:0]       prod;

  logic [tcsp_pkg::LEVEL_W-1:0]      lvl_in  [tcsp_pkg::NCH];
  logic [tcsp_pkg::LEVEL_W-1:0]      clip    [tcsp_pkg::NCH];
  logic [tcsp_pkg::LEVEL_W-1:0]      mx_in;
  logic [tcsp_pkg::PHASE_W-1:0]      phase_inc;
  logic [tcsp_pkg::PHASE_W-1:0]      phase_tick;
  logic                              tick_on [tcsp_pkg::NCH];
  logic [tcsp_pkg::FLOW_W-1:0]       flow_in [tcsp_pkg::NCH];

  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  // Level clipping and largest level, at least one
  assign lvl_in[0] = in_data.level_a;
  assign lvl_in[1] = in_data.level_b;
  assign lvl_in[2] = in_data.level_c;

  always_comb begin
    mx_in = tcsp_pkg::LEVEL_W'(1);
    for (int i = 0; i < tcsp_pkg::NCH; i++) begin
      clip[i] = (lvl_in[i] > tcsp_pkg::LEVEL_CAP) ? tcsp_pkg::LEVEL_CAP : lvl_in[i];
      if (clip[i] > mx_in) mx_in = clip[i];
    end
  end

  // Tick: saturating phase advance, restart above the cycle length while enabled
  assign phase_inc  = (phase == tcsp_pkg::PHASE_MAX) ? phase
                                                     : phase + tcsp_pkg::PHASE_W'(1);
  assign phase_tick = (active && (phase_inc > {1'b0, cycle_ms})) ? '0 : phase_inc;

  // Per-channel drive and flow for this beat
  always_comb begin
    for (int i = 0; i < tcsp_pkg::NCH; i++) begin
      tick_on[i] = phase_tick < {1'b0, on_time[i]};
      flow_in[i] = '0;
      if (in_data.req_type == tcsp_pkg::REQ_TICK) begin
        if (active && was_on[i] && !tick_on[i]) flow_in[i] = tcsp_pkg::FLOW_W'(on_time[i]);
      end else if (in_data.req_type == tcsp_pkg::REQ_DISABLE) begin
        if (active && was_on[i]) flow_in[i] = tcsp_pkg::FLOW_W'(phase);
      end
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcsp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and strobes
  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod;
    div_req.divisor  = mx;
    unique case (state)
      tcsp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (in_data.req_type == tcsp_pkg::REQ_SET) ? tcsp_pkg::ST_MUL
                                                              : tcsp_pkg::ST_DONE;
        end
      end
      tcsp_pkg::ST_MUL:  state_next = tcsp_pkg::ST_LOAD;
      tcsp_pkg::ST_LOAD: begin
        div_req.start = 1'b1;
        state_next    = tcsp_pkg::ST_DIV;
      end
      tcsp_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_next = (ch == tcsp_pkg::CH_W'(tcsp_pkg::NCH - 1)) ? tcsp_pkg::ST_DONE
                                                                 : tcsp_pkg::ST_MUL;
        end
      end
      tcsp_pkg::ST_DONE: begin
        if (out_free) state_next = tcsp_pkg::ST_IDLE;
      end
      default: state_next = tcsp_pkg::ST_IDLE;
    endcase
  end

  tcsp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Channel state, phase and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_ms <= tcsp_pkg::CYCLE_RESET;
      active   <= 1'b0;
      phase    <= tcsp_pkg::PHASE_MAX;
      ch       <= '0;
      for (int i = 0; i < tcsp_pkg::NCH; i++) begin
        on_time[i] <= '0;
        was_on[i]  <= 1'b0;
      end
    end else begin
      if (cfg_valid) cycle_ms <= cfg_data;
      if (in_fire) begin
        unique case (in_data.req_type)
          tcsp_pkg::REQ_TICK: begin
            phase <= phase_tick;
            if (active) begin
              for (int i = 0; i < tcsp_pkg::NCH; i++) was_on[i] <= tick_on[i];
            end
          end
          tcsp_pkg::REQ_SET:    ch     <= '0;
          tcsp_pkg::REQ_ENABLE: active <= 1'b1;
          tcsp_pkg::REQ_DISABLE: begin
            active <= 1'b0;
            for (int i = 0; i < tcsp_pkg::NCH; i++) was_on[i] <= 1'b0;
          end
          default: ;
        endcase
      end
      if ((state == tcsp_pkg::ST_DIV) && div_rsp.done) begin
        on_time[ch] <= div_rsp.quotient;
        ch          <= ch + tcsp_pkg::CH_W'(1);
      end
    end
  end

  // Latched levels, beat flows and the multiplier register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < tcsp_pkg::NCH; i++) flow[i] <= flow_in[i];
      if (in_data.req_type == tcsp_pkg::REQ_SET) begin
        for (int i = 0; i < tcsp_pkg::NCH; i++) lv[i] <= clip[i];
        mx <= mx_in;
      end
    end
    if (state == tcsp_pkg::ST_MUL) begin
      prod <= tcsp_pkg::PROD_W'(lv[ch]) * tcsp_pkg::PROD_W'(cycle_ms);
    end
  end

  // Result beat built from the state after the item
  always_comb begin
    result.drive_a = was_on[0];
    result.drive_b = was_on[1];
    result.drive_c = was_on[2];
    result.flow_a  = flow[0];
    result.flow_b  = flow[1];
    result.flow_c  = flow[2];
    result.running = active;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == tcsp_pkg::ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == tcsp_pkg::ST_DONE) && out_free) out_data <= result;
  end

endmodule

// ===== rtl/tcsp_checker.sv =====
// Port-level checks for the three-channel slow PWM, bound to the top level.
// Depends on tcsp_pkg and the assertion macros header.
`include "three_channel_proportional_slow_pwm_defines.svh"

module tcsp_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input tcsp_pkg::out_t out_data
);

  // A stalled result beat holds
  `TCSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // An accepted beat keeps the input closed while it is worked on
  `TCSP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // No pump runs while the block is disabled
  `TCSP_ASSERT_NOW(a_off_when_stopped, out_valid && !out_data.running,
    !out_data.drive_a && !out_data.drive_b && !out_data.drive_c)

  // Flow is only reported by a channel that is off
  `TCSP_ASSERT_NOW(a_flow_when_off, out_valid,
    (out_data.flow_a == '0 || !out_data.drive_a) &&
    (out_data.flow_b == '0 || !out_data.drive_b) &&
    (out_data.flow_c == '0 || !out_data.drive_c))

endmodule

bind three_channel_proportional_slow_pwm tcsp_checker u_checker (.*);

// ===== tb/sv/three_channel_proportional_slow_pwm_checker.sv =====
`timescale 1ns / 100ps
// Checker for the three-channel slow PWM: watches the request, result and cycle-length
// channels, predicts every result beat and compares it field by field.
// Depends on tcsp_pkg for the beat types, request codes and widths.
module three_channel_proportional_slow_pwm_checker
  import tcsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_t                   in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_t                  out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CYCLE_BITS-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    results_checked
);

  // Predicted pump state
  logic                  enabled;
  logic [PHASE_W-1:0]    phase_ms;
  logic [CYCLE_BITS-1:0] on_ms [NCH];
  logic                  pump_on [NCH];
  logic [CYCLE_BITS-1:0] cycle_len;

  out_t pump_results_due [$];
  out_t want;
  int   errors;
  int   seen;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $realtime, seen, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned exp_val);
    if (got != exp_val) begin
      flag_mismatch($sformatf("%s is %0d, predicted %0d", name, got, exp_val));
    end
  endtask

  // Applies one request beat to the predicted state and returns its result
  function automatic out_t pwm_advance(input in_t beat);
    out_t              r;
    logic [FLOW_W-1:0] flow [NCH];
    logic [LEVEL_W-1:0] lvl [NCH];
    int                peak;
    r = '0;
    for (int i = 0; i < NCH; i++) flow[i] = '0;
    case (beat.req_type)
      REQ_TICK: begin
        if (phase_ms != PHASE_MAX) phase_ms = phase_ms + 1'b1;
        if (enabled) begin
          // strictly above the cycle length restarts, so a period is cycle_len + 1 ticks
          if (phase_ms > cycle_len) phase_ms = '0;
          for (int i = 0; i < NCH; i++) begin
            if (pump_on[i] && !(phase_ms < on_ms[i])) flow[i] = FLOW_W'(on_ms[i]);
            pump_on[i] = phase_ms < on_ms[i];
          end
        end
      end
      REQ_SET: begin
        lvl[0] = beat.level_a;
        lvl[1] = beat.level_b;
        lvl[2] = beat.level_c;
        peak = 1;
        for (int i = 0; i < NCH; i++) begin
          if (lvl[i] > LEVEL_CAP) lvl[i] = LEVEL_CAP;
          if (int'(lvl[i]) > peak) peak = int'(lvl[i]);
        end
        // outputs hold until the next tick
        for (int i = 0; i < NCH; i++) begin
          on_ms[i] = CYCLE_BITS'((int'(lvl[i]) * int'(cycle_len)) / peak);
        end
      end
      REQ_ENABLE: begin
        enabled = 1'b1;
      end
      REQ_DISABLE: begin
        // pumps still on report the part of the cycle already run
        if (enabled) begin
          enabled = 1'b0;
          for (int i = 0; i < NCH; i++) begin
            if (pump_on[i]) flow[i] = phase_ms;
            pump_on[i] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.drive_a = pump_on[0];
    r.drive_b = pump_on[1];
    r.drive_c = pump_on[2];
    r.flow_a  = flow[0];
    r.flow_b  = flow[1];
    r.flow_c  = flow[2];
    r.running = enabled;
    return r;
  endfunction

  // Result beats are checked before the request beat of the same edge is predicted
  always @(posedge clk) begin
    if (rst) begin
      enabled   = 1'b0;
      phase_ms  = PHASE_MAX;
      cycle_len = CYCLE_RESET;
      for (int i = 0; i < NCH; i++) begin
        on_ms[i]   = '0;
        pump_on[i] = 1'b0;
      end
      pump_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) cycle_len = cfg_data;
      if (out_valid && out_ready) begin
        if (pump_results_due.size() == 0) begin
          flag_mismatch("arrived with nothing predicted");
        end else begin
          want = pump_results_due.pop_front();
          check_field("drive_a", 32'(out_data.drive_a), 32'(want.drive_a));
          check_field("drive_b", 32'(out_data.drive_b), 32'(want.drive_b));
          check_field("drive_c", 32'(out_data.drive_c), 32'(want.drive_c));
          check_field("flow_a",  32'(out_data.flow_a),  32'(want.flow_a));
          check_field("flow_b",  32'(out_data.flow_b),  32'(want.flow_b));
          check_field("flow_c",  32'(out_data.flow_c),  32'(want.flow_c));
          check_field("running", 32'(out_data.running), 32'(want.running));
        end
        seen++;
      end
      if (in_valid && in_ready) pump_results_due.push_back(pwm_advance(in_data));
    end
    pending         <= pump_results_due.size();
    fail_count      <= errors;
    results_checked <= seen;
  end

endmodule

// ===== tb/sv/three_channel_proportional_slow_pwm_tb.sv =====
`timescale 1ns / 100ps
// Top of the slow PWM testbench: clock, reset, request and cycle-length stimulus,
// result back-pressure and the verdict. Depends on tcsp_pkg, the block and its checker.
module three_channel_proportional_slow_pwm_tb;
  import tcsp_pkg::*;

  localparam int PHASES       = 10;
  localparam int PHASE_BEATS  = 113;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 4;
  localparam int TAIL         = 50;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CYCLE_BITS-1:0] cfg_data;

  int fail_count;
  int pending;
  int results_checked;
  int items_sent;
  int cycle_writes;
  int burst_left;

  three_channel_proportional_slow_pwm dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  three_channel_proportional_slow_pwm_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic in_t make_req(input req_t r, input logic [LEVEL_W-1:0] a,
                                   input logic [LEVEL_W-1:0] b,
                                   input logic [LEVEL_W-1:0] c);
    in_t beat;
    beat.req_type = r;
    beat.level_a  = a;
    beat.level_b  = b;
    beat.level_c  = c;
    return beat;
  endfunction

  // Mostly ticks, so that cycles run through; levels are random on every beat
  function automatic in_t random_req();
    int   pick;
    req_t r;
    pick = $urandom_range(0, 99);
    if (pick < 84)      r = REQ_TICK;
    else if (pick < 92) r = REQ_SET;
    else if (pick < 96) r = REQ_ENABLE;
    else                r = REQ_DISABLE;
    return make_req(r, LEVEL_W'($urandom_range(0, 127)), LEVEL_W'($urandom_range(0, 127)),
                    LEVEL_W'($urandom_range(0, 127)));
  endfunction

  // Offers one beat; valid drops only at the start of a gap between bursts
  task automatic send_item(input in_t beat);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
  endtask

  // Waits until every predicted result has been taken, then waits out the settle time
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_cycle(input logic [CYCLE_BITS-1:0] len);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cycle_writes++;
  endtask

  // Receiver: stretches of differing stall patterns, one long hold-off
  initial begin
    rx_mode_t mode;
    int       stretch;
    int       hold;
    int       cyc;
    bit       held;
    out_ready = 1'b0;
    mode      = RX_OPEN;
    stretch   = 0;
    hold      = 0;
    cyc       = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!held && items_sent >= HOLD_AT) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        if (stretch == 0) begin
          mode    = rx_mode_t'($urandom_range(RX_OPEN, RX_PERIODIC));
          stretch = $urandom_range(10, 150);
        end
        stretch--;
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= (cyc % 3 == 0);
        endcase
      end
    end
  end

  // Watchdog: too long without any beat on any channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout after %0d cycles without a beat", STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int unsigned plan [PHASES];
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    items_sent   = 0;
    cycle_writes = 0;
    burst_left   = 0;
    plan = '{0, 1, 1023, 2, 500, 0, 0, 0, 0, 0};
    for (int i = 5; i < PHASES; i++) plan[i] = $urandom_range(3, 40);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: short cycle so that whole periods fit in a few ticks
    write_cycle(4);
    send_item(make_req(REQ_TICK, 0, 0, 0));         // disabled, phase saturated
    send_item(make_req(REQ_DISABLE, 0, 0, 0));      // disable while disabled
    send_item(make_req(REQ_SET, 127, 50, 0));       // clipping to 100
    send_item(make_req(REQ_ENABLE, 0, 0, 0));
    send_item(make_req(REQ_ENABLE, 0, 0, 0));       // enable while enabled
    repeat (6) send_item(make_req(REQ_TICK, 0, 0, 0)); // stale phase restart, edges
    send_item(make_req(REQ_SET, 0, 0, 0));          // all zero, divisor of one
    send_item(make_req(REQ_TICK, 0, 0, 0));
    send_item(make_req(REQ_SET, 100, 101, 1));
    repeat (3) send_item(make_req(REQ_TICK, 0, 0, 0));
    send_item(make_req(REQ_DISABLE, 0, 0, 0));      // pumps on report elapsed phase
    send_item(make_req(REQ_TICK, 127, 127, 127));
    send_item(make_req(REQ_SET, 127, 127, 127));
    send_item(make_req(REQ_ENABLE, 0, 0, 0));
    repeat (2) send_item(make_req(REQ_TICK, 0, 0, 0));
    send_item(make_req(REQ_DISABLE, 0, 0, 0));

    // Random: one cycle length per phase, written with the block idle
    for (int ph = 0; ph < PHASES; ph++) begin
      drain(SETTLE);
      write_cycle(CYCLE_BITS'(plan[ph]));
      repeat (PHASE_BEATS) send_item(random_req());
    end

    drain(TAIL);
    $display("Sent %0d request beats under %0d cycle-length settings.",
             items_sent, cycle_writes);
    $display("Checked %0d result beats, %0d mismatches.", results_checked, fail_count);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tcsp_pkg.sv
rtl/tcsp_div.sv
rtl/three_channel_proportional_slow_pwm.sv
rtl/tcsp_checker.sv
tb/sv/three_channel_proportional_slow_pwm_checker.sv
tb/sv/three_channel_proportional_slow_pwm_tb.sv
